@@ rtl/core/fpte_pkg.sv @@
`timescale 1ns / 1ps

package fpte_pkg;

    localparam int FPTE_TABLE_FRAMES = 64;
    localparam int ENTRIES = 512;
    localparam int IDX_W = 9;
    localparam int ENT_W = 64;
    localparam int CNT_W = 10;
    localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;

    localparam int IN_DATA_W = 168;
    localparam int OUT_DATA_W = 96;

    localparam logic [ENT_W-1:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
    localparam logic [ENT_W-1:0] BIT_P = 64'h1;
    localparam logic [ENT_W-1:0] BIT_RW = 64'h2;
    localparam logic [ENT_W-1:0] BIT_US = 64'h4;

    localparam logic [1:0] FUNC_MAP = 2'd0;
    localparam logic [1:0] FUNC_UNMAP = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;
    localparam logic [1:0] FUNC_NOP = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NOFRAME = 2'd1;
    localparam logic [1:0] ST_NOTMAPPED = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_RD,
        OP_WALK,
        OP_SCAN_START,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_ALLOC,
        OP_CNT_RD,
        OP_CNT_UP,
        OP_CNT_DN,
        OP_ENT_ALLOC,
        OP_ENT_LEAF,
        OP_UNMAP_LEAF,
        OP_LOOKUP_RES,
        OP_NOTMAP,
        OP_FAIL,
        OP_FREE,
        OP_PCLR,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic in_ready;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic is_map;
        logic is_unmap;
        logic is_lookup;
        logic is_nop;
        logic lvl_last;
        logic d_zero;
        logic ent_present;
        logic child_ok;
        logic scan_end;
        logic scan_free;
        logic cnt_zero;
        logic out_busy;
        logic clr_last;
    } stat_t;

    typedef struct packed {
        logic             used;
        logic [CNT_W-1:0] count;
    } meta_t;

endpackage

@@ rtl/core/fpte_dp.sv @@
`timescale 1ns / 1ps

module fpte_dp #(
    parameter int TABLE_FRAMES = fpte_pkg::FPTE_TABLE_FRAMES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fpte_pkg::cmd_t                 cmd,
    output fpte_pkg::stat_t                stat,
    input  logic [fpte_pkg::IN_DATA_W-1:0] in_data,
    input  logic [1:0]                     in_user,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [fpte_pkg::OUT_DATA_W-1:0] out_data,
    output logic [1:0]                     out_user
);
    import fpte_pkg::*;

    localparam int FW = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int AW = FW + IDX_W;
    localparam int DEPTH = TABLE_FRAMES * ENTRIES;

    logic [1:0]       func_reg, func_next;
    logic [47:0]      va_reg, va_next;
    logic [51:0]      pa_reg, pa_next;
    logic [63:0]      flags_reg, flags_next;
    logic [1:0]       d_reg, d_next;
    logic [FW-1:0]    tf_reg [4];
    logic [FW-1:0]    tf_next [4];
    logic [FW:0]      scan_reg, scan_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic             res_mapped_reg, res_mapped_next;
    logic [51:0]      res_phys_reg, res_phys_next;
    logic             res_inval_reg, res_inval_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [1:0]       out_user_reg, out_user_next;

    logic [ENT_W-1:0] tbl_mem [DEPTH];
    logic [ENT_W-1:0] tbl_rdata_reg;
    meta_t            meta_mem [TABLE_FRAMES];
    meta_t            meta_rdata_reg;

    logic [IDX_W-1:0] idx;
    logic [FW-1:0]    cur_frame;
    logic [FW-1:0]    scan_frame;
    logic [39:0]      child_num;
    logic             child_ok;
    logic [AW-1:0]    tbl_addr;
    logic             tbl_we, tbl_re;
    logic [ENT_W-1:0] tbl_wdata;
    logic [FW-1:0]    meta_addr;
    logic             meta_we, meta_re;
    meta_t            meta_wdata;
    logic [CNT_W-1:0] cnt_up, cnt_dn;
    logic [35:0]      page;

    always_comb
    begin
        case (d_reg)
            2'd0: idx = va_reg[47:39];
            2'd1: idx = va_reg[38:30];
            2'd2: idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    assign cur_frame = tf_reg[d_reg];
    assign scan_frame = scan_reg[FW-1:0];
    assign child_num = tbl_rdata_reg[51:12];
    // intermediate entry must point at a real table frame
    assign child_ok = tbl_rdata_reg[0] && (child_num != 40'd0)
                      && (child_num < 40'(TABLE_FRAMES));

    assign cnt_up = (meta_rdata_reg.count == CNT_MAX) ? meta_rdata_reg.count
                                                     : meta_rdata_reg.count + 1'b1;
    assign cnt_dn = (meta_rdata_reg.count == '0) ? meta_rdata_reg.count
                                                 : meta_rdata_reg.count - 1'b1;

    assign tbl_addr = (cmd.op == OP_CLEAR) ? clr_reg : {cur_frame, idx};
    assign tbl_re = (cmd.op == OP_RD);

    always_comb
    begin
        tbl_we = 1'b0;
        tbl_wdata = '0;
        case (cmd.op)
            OP_CLEAR:      tbl_we = 1'b1;
            OP_UNMAP_LEAF: tbl_we = 1'b1;
            OP_PCLR:       tbl_we = 1'b1;
            OP_WALK:
            begin
                tbl_we = (func_reg == FUNC_MAP);
                tbl_wdata = tbl_rdata_reg | BIT_P | BIT_RW | BIT_US;
            end
            OP_ENT_ALLOC:
            begin
                tbl_we = 1'b1;
                tbl_wdata = (tbl_rdata_reg & ~ADDR_MASK) | (64'(scan_frame) << 12)
                            | BIT_P | BIT_RW | BIT_US;
            end
            OP_ENT_LEAF:
            begin
                tbl_we = 1'b1;
                tbl_wdata = (tbl_rdata_reg & ~ADDR_MASK) | (64'(pa_reg) & ADDR_MASK)
                            | flags_reg | BIT_P | BIT_RW;
            end
            default: tbl_we = 1'b0;
        endcase
    end

    always_comb
    begin
        meta_we = 1'b0;
        meta_wdata = '0;
        case (cmd.op)
            OP_CLEAR:
            begin
                meta_we = (clr_reg < AW'(TABLE_FRAMES));
                meta_wdata.used = (clr_reg == '0);
            end
            OP_ALLOC:
            begin
                meta_we = 1'b1;
                meta_wdata.used = 1'b1;
            end
            OP_CNT_UP:
            begin
                meta_we = 1'b1;
                meta_wdata.used = meta_rdata_reg.used;
                meta_wdata.count = cnt_up;
            end
            OP_CNT_DN:
            begin
                meta_we = 1'b1;
                meta_wdata.used = meta_rdata_reg.used;
                meta_wdata.count = cnt_dn;
            end
            OP_FREE: meta_we = 1'b1;
            default: meta_we = 1'b0;
        endcase
    end

    always_comb
    begin
        case (cmd.op)
            OP_CLEAR:   meta_addr = clr_reg[FW-1:0];
            OP_SCAN_RD: meta_addr = scan_frame;
            OP_ALLOC:   meta_addr = scan_frame;
            default:    meta_addr = cur_frame;
        endcase
    end

    assign meta_re = (cmd.op == OP_SCAN_RD) || (cmd.op == OP_CNT_RD);

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_addr] <= tbl_wdata;
        end
        if (tbl_re)
        begin
            tbl_rdata_reg <= tbl_mem[tbl_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_addr] <= meta_wdata;
        end
        if (meta_re)
        begin
            meta_rdata_reg <= meta_mem[meta_addr];
        end
    end

    assign page = res_inval_reg ? va_reg[47:12] : 36'd0;

    always_comb
    begin
        func_next = func_reg;
        va_next = va_reg;
        pa_next = pa_reg;
        flags_next = flags_reg;
        d_next = d_reg;
        tf_next = tf_reg;
        scan_next = scan_reg;
        clr_next = clr_reg;
        res_status_next = res_status_reg;
        res_mapped_next = res_mapped_reg;
        res_phys_next = res_phys_reg;
        res_inval_next = res_inval_reg;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (cmd.op)
            OP_CLEAR: clr_next = clr_reg + 1'b1;
            OP_LOAD:
            begin
                func_next = in_user;
                va_next = in_data[47:0];
                pa_next = in_data[99:48];
                flags_next = in_data[163:100];
                d_next = 2'd0;
                tf_next[0] = '0;
                res_status_next = ST_DONE;
                res_mapped_next = 1'b0;
                res_phys_next = '0;
                res_inval_next = 1'b0;
            end
            OP_WALK:
            begin
                tf_next[d_reg + 2'd1] = child_num[FW-1:0];
                d_next = d_reg + 2'd1;
            end
            OP_SCAN_START: scan_next = (FW+1)'(1);
            OP_SCAN_NEXT:  scan_next = scan_reg + 1'b1;
            OP_ENT_ALLOC:
            begin
                tf_next[d_reg + 2'd1] = scan_frame;
                d_next = d_reg + 2'd1;
            end
            OP_ENT_LEAF:   res_inval_next = 1'b1;
            OP_UNMAP_LEAF: res_inval_next = 1'b1;
            OP_LOOKUP_RES:
            begin
                res_mapped_next = 1'b1;
                res_phys_next = {tbl_rdata_reg[51:12], va_reg[11:0]};
            end
            OP_NOTMAP: res_status_next = ST_NOTMAPPED;
            OP_FAIL:   res_status_next = ST_NOFRAME;
            OP_FREE:   d_next = d_reg - 2'd1;
            OP_EMIT:
            begin
                out_valid_next = 1'b1;
                out_user_next = res_status_reg;
                out_data_next = {6'd0, page, res_inval_reg, res_phys_reg, res_mapped_reg};
            end
            default: d_next = d_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= 2'd0;
            scan_reg <= '0;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            d_reg <= d_next;
            scan_reg <= scan_next;
            clr_reg <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        va_reg <= va_next;
        pa_reg <= pa_next;
        flags_reg <= flags_next;
        tf_reg <= tf_next;
        res_status_reg <= res_status_next;
        res_mapped_reg <= res_mapped_next;
        res_phys_reg <= res_phys_next;
        res_inval_reg <= res_inval_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign stat.is_map = (func_reg == FUNC_MAP);
    assign stat.is_unmap = (func_reg == FUNC_UNMAP);
    assign stat.is_lookup = (func_reg == FUNC_LOOKUP);
    assign stat.is_nop = (func_reg == FUNC_NOP);
    assign stat.lvl_last = (d_reg == 2'd3);
    assign stat.d_zero = (d_reg == 2'd0);
    assign stat.ent_present = tbl_rdata_reg[0];
    assign stat.child_ok = child_ok;
    assign stat.scan_end = (scan_reg == (FW+1)'(TABLE_FRAMES));
    assign stat.scan_free = !meta_rdata_reg.used;
    assign stat.cnt_zero = (cnt_dn == '0);
    assign stat.out_busy = out_valid_reg && !out_ready;
    assign stat.clr_last = (clr_reg == AW'(DEPTH - 1));

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;
    assign out_user = out_user_reg;

endmodule

@@ rtl/core/fpte_ctrl.sv @@
`timescale 1ns / 1ps

module fpte_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  fpte_pkg::stat_t stat,
    output fpte_pkg::cmd_t  cmd
);
    import fpte_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_RD      = 13'b0000000000100,
        S_EVAL    = 13'b0000000001000,
        S_SCAN_RD = 13'b0000000010000,
        S_SCAN_CK = 13'b0000000100000,
        S_ALLOC   = 13'b0000001000000,
        S_CNT_RD  = 13'b0000010000000,
        S_CNT_WR  = 13'b0000100000000,
        S_ENT_WR  = 13'b0001000000000,
        S_FREE    = 13'b0010000000000,
        S_PCLR    = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    op_t    op;

    always_comb
    begin
        state_next = state_reg;
        op = OP_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                op = OP_CLEAR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op = OP_LOAD;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                op = OP_RD;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (stat.is_nop)
                begin
                    state_next = S_DONE;
                end
                else if (!stat.lvl_last)
                begin
                    if (stat.child_ok)
                    begin
                        op = OP_WALK;
                        state_next = S_RD;
                    end
                    else if (stat.is_map)
                    begin
                        op = OP_SCAN_START;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        op = OP_NOTMAP;
                        state_next = S_DONE;
                    end
                end
                else if (stat.is_map)
                begin
                    state_next = stat.ent_present ? S_ENT_WR : S_CNT_RD;
                end
                else if (!stat.ent_present)
                begin
                    op = OP_NOTMAP;
                    state_next = S_DONE;
                end
                else if (stat.is_lookup)
                begin
                    op = OP_LOOKUP_RES;
                    state_next = S_DONE;
                end
                else
                begin
                    op = OP_UNMAP_LEAF;
                    state_next = S_CNT_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    op = OP_FAIL;
                    state_next = S_DONE;
                end
                else
                begin
                    op = OP_SCAN_RD;
                    state_next = S_SCAN_CK;
                end
            end
            S_SCAN_CK:
            begin
                if (stat.scan_free)
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    op = OP_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end
            end
            S_ALLOC:
            begin
                op = OP_ALLOC;
                // parent count rises only when the entry was not present
                state_next = stat.ent_present ? S_ENT_WR : S_CNT_RD;
            end
            S_CNT_RD:
            begin
                op = OP_CNT_RD;
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                if (stat.is_map)
                begin
                    op = OP_CNT_UP;
                    state_next = S_ENT_WR;
                end
                else
                begin
                    op = OP_CNT_DN;
                    state_next = (stat.cnt_zero && !stat.d_zero) ? S_FREE : S_DONE;
                end
            end
            S_ENT_WR:
            begin
                if (stat.lvl_last)
                begin
                    op = OP_ENT_LEAF;
                    state_next = S_DONE;
                end
                else
                begin
                    op = OP_ENT_ALLOC;
                    state_next = S_RD;
                end
            end
            S_FREE:
            begin
                op = OP_FREE;
                state_next = S_PCLR;
            end
            S_PCLR:
            begin
                op = OP_PCLR;
                state_next = S_CNT_RD;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    op = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.op = op;
    assign cmd.in_ready = (state_reg == S_IDLE);

endmodule

@@ rtl/core/four_level_page_table_engine.sv @@
`timescale 1ns / 1ps
// four-level page table engine with an internal pool of table frames
// slave channel s_axis_*: one request word per operation, tuser holds func
// (map, unmap, lookup, nop); master channel m_axis_*: one result word per
// request, tuser holds status
// after reset a clearing pass writes every table entry and frame record,
// with s_axis_tready low until it ends
// one request at a time: tready is high only while the engine is idle
// the walk goes over the single-port table memory, each level reading its
// entry and then evaluating it; each missing level on map scans the frame
// records for the lowest free frame, and unmap frees each table it empties
// the result sits in an output register; a new request is taken while it
// waits, and a second result waits in the result registers, the controller
// held in its done state, until the stalled receiver takes the first
module four_level_page_table_engine #(
    parameter int TABLE_FRAMES = fpte_pkg::FPTE_TABLE_FRAMES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // va[47:0], page address[99:48], map_flags[163:100], zero fill
    input  logic [fpte_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // mapped[0], phys_result[52:1], tlb_invalidate[53], invalidate_page[89:54]
    output logic [fpte_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]                      m_axis_tuser
);
    import fpte_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fpte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    fpte_dp #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

    assign s_axis_tready = cmd.in_ready;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("undefined status code");

    a_inval_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[53]) |-> (m_axis_tuser == ST_DONE && !m_axis_tdata[0]))
        else $error("invalidate without a completed map or unmap");

    a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[52:1] == 52'd0))
        else $error("physical result without a mapping");

endmodule

@@ verif/tb_four_level_page_table_engine.sv @@
`timescale 1ns / 1ps

module tb_four_level_page_table_engine;

    import fpte_pkg::*;

    localparam int NFRAMES = FPTE_TABLE_FRAMES;

    typedef struct {
        logic [1:0]  func;
        logic [47:0] va;
        logic [51:0] pa;
        logic [63:0] flags;
    } req_t;

    typedef struct {
        logic [1:0]  status;
        logic        mapped;
        logic [51:0] phys;
        logic        inval;
        logic [35:0] page;
    } walk_res_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    four_level_page_table_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor state
    logic [63:0]      tbl_mem [int];
    logic             frame_busy [NFRAMES];
    logic [CNT_W-1:0] live_cnt [NFRAMES];

    req_t        pending_reqs[$];
    walk_res_t   expected_results[$];
    req_t        cur_req;
    logic [47:0] va_pool[$];
    logic        word_taken;
    logic        quiet;
    logic        hold_off;
    int          send_gap;
    int          recv_gap;
    int          n_accepted;
    int          n_results;
    int          n_errors;
    int          n_map_ok;
    int          n_noframe;
    int          n_hits;
    int          n_freed;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] rd_ent(int k);
        if (tbl_mem.exists(k))
            return tbl_mem[k];
        return 64'd0;
    endfunction

    function automatic int lvl_idx(logic [47:0] va, int d);
        return int'((va >> (39 - 9 * d)) & 48'h1FF);
    endfunction

    function automatic int child_frame(logic [63:0] e);
        logic [63:0] f;
        if (!e[0])
            return 0;
        f = (e & ADDR_MASK) >> 12;
        if (f == 0 || f >= NFRAMES)
            return 0;
        return int'(f);
    endfunction

    function automatic int grab_frame();
        for (int f = 1; f < NFRAMES; f++)
        begin
            if (!frame_busy[f])
            begin
                frame_busy[f] = 1'b1;
                for (int i = 0; i < ENTRIES; i++)
                    tbl_mem.delete(f * ENTRIES + i);
                live_cnt[f] = '0;
                return f;
            end
        end
        return 0;
    endfunction

    function automatic void cnt_up(int f);
        if (live_cnt[f] < CNT_MAX)
            live_cnt[f]++;
    endfunction

    function automatic void cnt_dn(int f);
        if (live_cnt[f] > 0)
            live_cnt[f]--;
    endfunction

    function automatic walk_res_t predict_walk(req_t r);
        walk_res_t   res;
        int          cur;
        int          nxt;
        int          k;
        logic        ok;
        logic [63:0] e;
        int          tf[4];
        int          ti[4];
        res = '{ST_DONE, 1'b0, 52'd0, 1'b0, 36'd0};
        if (r.func == FUNC_MAP)
        begin
            cur = 0;
            ok = 1'b1;
            for (int d = 0; d < 3; d++)
            begin
                k = cur * ENTRIES + lvl_idx(r.va, d);
                e = rd_ent(k);
                nxt = child_frame(e);
                if (nxt == 0)
                begin
                    nxt = grab_frame();
                    if (nxt == 0)
                    begin
                        ok = 1'b0;
                        break;
                    end
                    if (!e[0])
                        cnt_up(cur);
                    e = (e & ~ADDR_MASK) | (64'(nxt) << 12);
                end
                e |= BIT_P | BIT_RW | BIT_US;
                tbl_mem[k] = e;
                cur = nxt;
            end
            if (ok)
            begin
                k = cur * ENTRIES + lvl_idx(r.va, 3);
                e = rd_ent(k);
                if (!e[0])
                    cnt_up(cur);
                e = (e & ~ADDR_MASK) | ({12'd0, r.pa} & ADDR_MASK);
                tbl_mem[k] = e | r.flags | BIT_P | BIT_RW;
                res.inval = 1'b1;
                n_map_ok++;
            end
            else
            begin
                res.status = ST_NOFRAME;
                n_noframe++;
            end
        end
        else if (r.func == FUNC_UNMAP || r.func == FUNC_LOOKUP)
        begin
            ok = 1'b1;
            e = '0;
            tf[0] = 0;
            for (int d = 0; d < 4; d++)
            begin
                ti[d] = lvl_idx(r.va, d);
                e = rd_ent(tf[d] * ENTRIES + ti[d]);
                if (d < 3)
                begin
                    tf[d + 1] = child_frame(e);
                    if (tf[d + 1] == 0)
                    begin
                        ok = 1'b0;
                        break;
                    end
                end
                else if (!e[0])
                    ok = 1'b0;
            end
            if (!ok)
                res.status = ST_NOTMAPPED;
            else if (r.func == FUNC_LOOKUP)
            begin
                res.mapped = 1'b1;
                res.phys = e[51:0] & ADDR_MASK[51:0] | {40'd0, r.va[11:0]};
                n_hits++;
            end
            else
            begin
                tbl_mem.delete(tf[3] * ENTRIES + ti[3]);
                cnt_dn(tf[3]);
                res.inval = 1'b1;
                // free empty tables bottom up
                for (int d = 3; d >= 1; d--)
                begin
                    if (live_cnt[tf[d]] != 0)
                        break;
                    frame_busy[tf[d]] = 1'b0;
                    tbl_mem.delete(tf[d - 1] * ENTRIES + ti[d - 1]);
                    cnt_dn(tf[d - 1]);
                    n_freed++;
                end
            end
        end
        if (res.inval)
            res.page = r.va[47:12];
        return res;
    endfunction

    function automatic logic [47:0] pool_va();
        return va_pool[$urandom_range(0, va_pool.size() - 1)];
    endfunction

    function automatic req_t make_req(logic [1:0] f, logic [47:0] va,
                                      logic [51:0] pa, logic [63:0] fl);
        req_t r;
        r.func = f;
        r.va = va;
        r.pa = pa;
        r.flags = fl;
        return r;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // input side: new words at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && !word_taken))
        begin
        end
        else if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            s_axis_tvalid <= 1'b0;
        end
        else if (pending_reqs.size() > 0)
        begin
            cur_req = pending_reqs.pop_front();
            s_axis_tdata <= {4'd0, cur_req.flags, cur_req.pa, cur_req.va};
            s_axis_tuser <= cur_req.func;
            s_axis_tvalid <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
                send_gap <= $urandom_range(1, 17);
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
                recv_gap <= $urandom_range(1, 17);
        end
    end

    // predict on accept, check results in order
    always @(posedge clk)
    begin
        walk_res_t exp_r;
        word_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h status %0d", $time,
                         m_axis_tdata, m_axis_tuser);
                n_errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_axis_tuser !== exp_r.status || m_axis_tdata[0] !== exp_r.mapped
                    || m_axis_tdata[52:1] !== exp_r.phys
                    || m_axis_tdata[53] !== exp_r.inval
                    || m_axis_tdata[89:54] !== exp_r.page)
                begin
                    $display("%0t: mismatch expected st %0d map %0d pa %h inv %0d pg %h",
                             $time, exp_r.status, exp_r.mapped, exp_r.phys,
                             exp_r.inval, exp_r.page);
                    $display("%0t:          actual   st %0d map %0d pa %h inv %0d pg %h",
                             $time, m_axis_tuser, m_axis_tdata[0], m_axis_tdata[52:1],
                             m_axis_tdata[53], m_axis_tdata[89:54]);
                    n_errors++;
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_results.push_back(predict_walk(make_req(s_axis_tuser,
                s_axis_tdata[47:0], s_axis_tdata[99:48], s_axis_tdata[163:100])));
            n_accepted++;
        end
    end

    // long receiver hold-off so the engine backs up
    initial
    begin
        wait (n_accepted >= 400);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("timeout after %0d words in, %0d out", n_accepted, n_results);
        $display("FAIL four_level_page_table_engine");
        $finish;
    end

    initial
    begin
        logic [47:0] va;
        logic [47:0] va_hi;
        int          pick;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_NOP;
        m_axis_tready = 1'b0;
        word_taken = 1'b0;
        quiet = 1'b0;
        hold_off = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        n_accepted = 0;
        n_results = 0;
        n_errors = 0;
        n_map_ok = 0;
        n_noframe = 0;
        n_hits = 0;
        n_freed = 0;
        for (int f = 0; f < NFRAMES; f++)
        begin
            frame_busy[f] = (f == 0);
            live_cnt[f] = '0;
        end

        va_hi = 48'hFFFF_FFFF_FFFF;
        // directed: extremes, remap, flags in the address bits, miss paths
        pending_reqs.push_back(make_req(FUNC_LOOKUP, 48'd0, '0, '0));
        pending_reqs.push_back(make_req(FUNC_UNMAP, va_hi, '0, '0));
        pending_reqs.push_back(make_req(FUNC_MAP, 48'd0, '0, '0));
        pending_reqs.push_back(make_req(FUNC_MAP, va_hi, {52{1'b1}}, {64{1'b1}}));
        pending_reqs.push_back(make_req(FUNC_LOOKUP, va_hi, '0, '0));
        pending_reqs.push_back(make_req(FUNC_LOOKUP, 48'h000, '0, '0));
        pending_reqs.push_back(make_req(FUNC_MAP, 48'h0_0000_0ABC, 52'hA_BCDE_F012_3456,
                                        64'h0000_0000_0055_5000));
        pending_reqs.push_back(make_req(FUNC_LOOKUP, 48'h0_0000_0FFF, '0, '0));
        pending_reqs.push_back(make_req(FUNC_NOP, va_hi, {52{1'b1}}, {64{1'b1}}));
        pending_reqs.push_back(make_req(FUNC_UNMAP, 48'd0, '0, '0));
        pending_reqs.push_back(make_req(FUNC_UNMAP, va_hi, '0, '0));
        pending_reqs.push_back(make_req(FUNC_LOOKUP, va_hi, '0, '0));
        // one fresh top-level slot per map: three frames each until the pool runs dry
        for (int i = 0; i < 22; i++)
        begin
            va = {9'(i * 23 + 1), 27'($urandom), 12'($urandom)};
            va_pool.push_back(va);
            pending_reqs.push_back(make_req(FUNC_MAP, va, 52'(rnd64()), 64'($urandom)));
        end

        for (int i = 0; i < 40; i++)
        begin
            va = {9'($urandom_range(0, 3) == 0 ? 9'h1FF : 9'($urandom_range(0, 3))),
                  9'($urandom_range(0, 1) ? 9'h1FF : 9'($urandom_range(0, 2))),
                  9'($urandom_range(0, 2)), 9'($urandom), 12'($urandom)};
            va_pool.push_back(va);
        end
        for (int i = 0; i < 1070; i++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 6) == 0)
            begin
                va = 48'(rnd64());
                va_pool[$urandom_range(0, va_pool.size() - 1)] = va;
            end
            else
            begin
                va = pool_va();
                va[11:0] = 12'($urandom);
            end
            pending_reqs.push_back(make_req(pick < 40 ? FUNC_MAP : pick < 65 ? FUNC_UNMAP
                                            : pick < 96 ? FUNC_LOOKUP : FUNC_NOP,
                                            va, 52'(rnd64()),
                                            $urandom_range(0, 3) == 0 ? rnd64()
                                                                      : 64'($urandom_range(0, 7))));
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_reqs.size() < 150);
        quiet = 1'b1;
        wait (pending_reqs.size() == 0 && !s_axis_tvalid);
        wait (expected_results.size() == 0);
        repeat (1000) @(posedge clk);
        $display("%0d requests, %0d results: %0d maps done, %0d out of frames",
                 n_accepted, n_results, n_map_ok, n_noframe);
        $display("%0d lookup hits, %0d table frames released by unmap", n_hits, n_freed);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("PASS four_level_page_table_engine");
        else
            $display("FAIL four_level_page_table_engine");
        $finish;
    end

endmodule

@@ four_level_page_table_engine.f @@
rtl/core/fpte_pkg.sv
rtl/core/fpte_dp.sv
rtl/core/fpte_ctrl.sv
rtl/core/four_level_page_table_engine.sv
verif/tb_four_level_page_table_engine.sv
